// File: hdl/bswr_pkg.sv
// Package for the bounded stack with remove-by-value.
// Holds request and result types, status codes and shared constants; no dependencies.
package bswr_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 4;

    localparam logic signed [DATA_W-1:0] EMPTY_DATA = '1;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NOP    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t                kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
    } result_t;

endpackage

// File: hdl/bswr_in_stage.sv
// Input register of the bounded stack: captures one request per cycle while it is not stalled.
// Depends on bswr_pkg for the request type.
module bswr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bswr_pkg::req_t req_in,
    input  logic           take,
    output logic           held_valid,
    output bswr_pkg::req_t held_req
);
    import bswr_pkg::*;

    logic held_valid_reg;
    logic held_valid_next;
    req_t held_req_reg;

    assign req_stall = held_valid_reg && !take;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (!req_stall)
        begin
            held_valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    // hold the payload until it is taken
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            held_req_reg <= req_in;
        end
    end

    assign held_valid = held_valid_reg;
    assign held_req   = held_req_reg;

endmodule

// File: hdl/bswr_core.sv
// Stack cells, occupancy and combinational request resolution.
// Top entry sits in cell 0; depends on bswr_pkg for types and codes.
module bswr_core #(
    parameter int DEPTH = bswr_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bswr_pkg::req_t    req,
    output bswr_pkg::result_t res
);
    import bswr_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] cell_reg  [DEPTH];
    logic [DATA_W-1:0] cell_next [DEPTH];
    logic [DATA_W-1:0] up_src    [DEPTH+1];
    logic [DATA_W-1:0] down_src  [DEPTH];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [DEPTH-1:0]  hit;
    logic [DEPTH-1:0]  at_or_below;
    logic              any_hit;
    logic [OCC_W+COUNT_W-1:0] count_wide;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit[i]    = (occ_reg > OCC_W'(i)) && (cell_reg[i] == req.value);
            up_src[i] = cell_reg[i];
        end
        up_src[DEPTH] = cell_reg[DEPTH-1];
        down_src[0]   = req.value;
        for (int i = 1; i < DEPTH; i++)
        begin
            down_src[i] = cell_reg[i-1];
        end
        // cells from the topmost match downward close the gap
        for (int i = 0; i < DEPTH; i++)
        begin
            at_or_below[i] = |(hit & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
        any_hit = |hit;
    end

    always_comb
    begin
        cell_next  = cell_reg;
        occ_next   = occ_reg;
        res.data   = '0;
        res.status = ST_OK;
        unique case (req.kind)
            REQ_PUSH:
            begin
                if (occ_reg == OCC_W'(DEPTH))
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        cell_next[i] = down_src[i];
                    end
                    occ_next = occ_reg + 1'b1;
                end
            end
            REQ_POP:
            begin
                if (occ_reg == '0)
                begin
                    res.status = ST_EMPTY;
                    res.data   = EMPTY_DATA;
                end
                else
                begin
                    res.data = cell_reg[0];
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        cell_next[i] = up_src[i+1];
                    end
                    occ_next = occ_reg - 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (!any_hit)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (at_or_below[i])
                        begin
                            cell_next[i] = up_src[i+1];
                        end
                    end
                    occ_next = occ_reg - 1'b1;
                end
            end
            REQ_NOP:
            begin
                res.status = ST_OK;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        count_wide = {{COUNT_W{1'b0}}, occ_next};
        res.count  = count_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (fire)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cell_reg <= cell_next;
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.kind == REQ_PUSH && res.status == ST_OK
        |=> occ_reg == $past(occ_reg) + 1'b1 && cell_reg[0] == $past(req.value))
        else $error("push did not land on top");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.kind == REQ_POP && res.status == ST_OK
        |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("pop did not shrink the stack");

    a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.kind == REQ_REMOVE && res.status == ST_OK
        |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("remove did not shrink the stack");

    a_remove_miss: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == ST_NOT_FOUND |=> $stable(occ_reg))
        else $error("failed remove changed occupancy");
`endif

endmodule

// File: hdl/bswr_out_stage.sv
// Result register of the bounded stack: holds one result until it is taken.
// Depends on bswr_pkg for the result type.
module bswr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bswr_pkg::result_t res_in,
    output logic              free,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output bswr_pkg::result_t res_out
);
    import bswr_pkg::*;

    logic    rsp_valid_reg;
    logic    rsp_valid_next;
    result_t res_reg;

    assign free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign res_out   = res_reg;

endmodule

// File: hdl/bounded_stack_with_remove_unit.sv
// Bounded LIFO stack of signed 32-bit words with push, pop and remove-by-value.
// Top level; instantiates bswr_in_stage, bswr_core and bswr_out_stage, uses bswr_pkg.
//
// Each request is captured in an input register and resolved combinationally; a remove
// compares the value against all DEPTH cells at once, picks the topmost match and shifts
// the cells below it. The result is placed in an output register, so after a request is
// accepted it passes through the input register and then the output register. One request
// is taken per cycle while the result side is not stalled, as the compare and shift across
// the cell row are combinational. No start-up pass is needed after reset.
module bounded_stack_with_remove_unit #(
    parameter int DEPTH = bswr_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          req_type,
    input  logic signed [bswr_pkg::DATA_W-1:0]  value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [bswr_pkg::DATA_W-1:0]  data,
    output logic [1:0]                          status,
    output logic [bswr_pkg::COUNT_W-1:0]        count
);
    import bswr_pkg::*;

    req_t    req_in;
    req_t    held_req;
    logic    held_valid;
    logic    free;
    logic    fire;
    result_t res_core;
    result_t res_out;

    assign req_in.kind  = req_kind_t'(req_type);
    assign req_in.value = value;
    assign fire         = held_valid && free;

    bswr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_in     (req_in),
        .take       (free),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    bswr_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (held_req),
        .res   (res_core)
    );

    bswr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_in    (res_core),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .res_out   (res_out)
    );

    assign data   = res_out.data;
    assign status = res_out.status;
    assign count  = res_out.count;

endmodule

// File: sim/tb.sv
// Self-checking testbench for bounded_stack_with_remove_unit: push, pop and remove-by-value.
// Random-gap driver and stalling monitor; results checked against an in-bench stack model.
// Depends on bswr_pkg and the bounded_stack_with_remove_unit RTL.
`timescale 1ns / 1ps

module tb;
    import bswr_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam int DIRECTED_N  = 24;
    localparam int RANDOM_N    = 1300;
    localparam int PHASE_LEN   = 50;
    localparam int HOLD_AT_A   = 300;
    localparam int HOLD_AT_B   = 900;
    localparam int HOLD_LEN    = 200;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct {
        req_kind_t                kind;
        logic signed [DATA_W-1:0] word;
        int unsigned              gap;
    } stack_req_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [1:0]                 req_type = REQ_PUSH;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic signed [DATA_W-1:0]   data;
    logic [1:0]                 status;
    logic [COUNT_W-1:0]         count;

    stack_req_t                 stack_reqs[$];
    result_t                    stack_results_due[$];
    logic signed [DATA_W-1:0]   stack_mem[STACK_DEPTH];
    int                         stack_fill = 0;
    logic signed [DATA_W-1:0]   word_pool[8];

    int unsigned n_queued = 0;
    int unsigned n_sent = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned req_idle = 0;
    int unsigned rsp_wait = 0;
    int unsigned rsp_hold = 0;
    int unsigned idle_cycles = 0;

    bounded_stack_with_remove_unit #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .data      (data),
        .status    (status),
        .count     (count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t stack_apply(input req_kind_t kind,
                                            input logic signed [DATA_W-1:0] word);
        result_t r;
        int      pos;
        r.data   = '0;
        r.status = ST_OK;
        case (kind)
            REQ_PUSH:
            begin
                if (stack_fill >= STACK_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    stack_mem[stack_fill] = word;
                    stack_fill++;
                end
            end
            REQ_POP:
            begin
                if (stack_fill == 0)
                begin
                    r.status = ST_EMPTY;
                    r.data   = EMPTY_DATA;
                end
                else
                begin
                    stack_fill--;
                    r.data = stack_mem[stack_fill];
                end
            end
            REQ_REMOVE:
            begin
                pos = stack_fill - 1;
                while (pos >= 0 && stack_mem[pos] !== word)
                    pos--;
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j < stack_fill - 1; j++)
                        stack_mem[j] = stack_mem[j + 1];
                    stack_fill--;
                end
            end
            default: ;
        endcase
        r.count = stack_fill[COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_req(input req_kind_t kind, input logic signed [DATA_W-1:0] word,
                             input int unsigned gap);
        stack_req_t rq;
        rq.kind = kind;
        rq.word = word;
        rq.gap  = gap;
        stack_reqs.push_back(rq);
        n_queued++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        if ($urandom_range(0, 1) == 0)
            return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic       taken;
        stack_req_t nxt;
        taken = req_valid && !req_stall;
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (taken)
            begin
                stack_results_due.push_back(stack_apply(req_kind_t'(req_type), value));
                n_sent++;
            end
            if (taken || !req_valid)
            begin
                if (stack_reqs.size() != 0 && req_idle >= stack_reqs[0].gap)
                begin
                    nxt = stack_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_type  <= nxt.kind;
                    value     <= nxt.word;
                    req_idle  = 0;
                end
                else
                begin
                    req_valid <= 1'b0;
                    req_idle++;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic    taken;
        result_t want;
        taken = rsp_valid && !rsp_stall;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (taken)
            begin
                if (stack_results_due.size() == 0)
                begin
                    $error("unexpected result: data %0d status %0d count %0d",
                           data, status, count);
                    n_errors++;
                end
                else
                begin
                    want = stack_results_due.pop_front();
                    if (data !== want.data)
                    begin
                        $error("data: expected %0d, actual %0d", want.data, data);
                        n_errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        n_errors++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, count);
                        n_errors++;
                    end
                end
                n_results++;
                if (n_results == HOLD_AT_A || n_results == HOLD_AT_B)
                    rsp_hold = HOLD_LEN;
                else if (((n_results / 128) % 3) == 1)
                    rsp_wait = 0;
                else
                    rsp_wait = $urandom_range(0, 8);
            end
            if (rsp_hold != 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold--;
            end
            else if (rsp_wait != 0)
            begin
                rsp_stall <= 1'b1;
                rsp_wait--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned pick;
        bit          calm;
        int unsigned gap;

        queue_req(REQ_POP,    32'sd0,             $urandom_range(0, 8));
        queue_req(REQ_REMOVE, 32'sd5,             $urandom_range(0, 8));
        queue_req(REQ_NOP,    32'sd0,             $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sh8000_0000,     $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sh7fff_ffff,     $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sd0,             $urandom_range(0, 8));
        queue_req(REQ_PUSH,   -32'sd1,            $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sh7fff_ffff,     $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sd1,             $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sd5,             $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sh7fff_ffff,     $urandom_range(0, 8));
        queue_req(REQ_PUSH,   32'sd42,            $urandom_range(0, 8));
        queue_req(REQ_NOP,    32'sh5555_aaaa,     $urandom_range(0, 8));
        queue_req(REQ_REMOVE, 32'sh7fff_ffff,     $urandom_range(0, 8));
        queue_req(REQ_REMOVE, 32'sh7fff_ffff,     $urandom_range(0, 8));
        queue_req(REQ_REMOVE, 32'sh8000_0000,     $urandom_range(0, 8));
        queue_req(REQ_REMOVE, 32'sd12345,         $urandom_range(0, 8));
        for (int i = 0; i < 6; i++)
            queue_req(REQ_POP, $urandom, $urandom_range(0, 8));
        queue_req(REQ_NOP,    -32'sd1,            $urandom_range(0, 8));

        while (n_queued < DIRECTED_N + RANDOM_N)
        begin
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            word_pool[0] = 32'sh8000_0000;
            word_pool[1] = 32'sh7fff_ffff;
            word_pool[2] = 32'sd0;
            word_pool[3] = -32'sd1;
            for (int k = 4; k < 8; k++)
                word_pool[k] = $urandom;
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                pick = $urandom_range(0, 99);
                gap  = calm ? 0 : $urandom_range(0, 8);
                case (mode)
                    0: pick = (pick < 65) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 3;
                    1: pick = (pick < 25) ? 0 : (pick < 70) ? 1 : (pick < 95) ? 2 : 3;
                    2: pick = (pick < 45) ? 0 : (pick < 55) ? 1 : (pick < 95) ? 2 : 3;
                    default: pick = (pick < 40) ? 0 : (pick < 70) ? 1 : (pick < 90) ? 2 : 3;
                endcase
                case (pick)
                    0: queue_req(REQ_PUSH, pick_word(), gap);
                    1: queue_req(REQ_POP, $urandom, gap);
                    2: queue_req(REQ_REMOVE, pick_word(), gap);
                    default: queue_req(REQ_NOP, $urandom, gap);
                endcase
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_sent == n_queued && stack_results_due.size() == 0))
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
